[hdl/assert_macros.svh]
// Assertion macros for the RTL of the response field parser.
// No dependencies; the including module must have signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define CRFP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Same-cycle implication.
`define CRFP_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define CRFP_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CRFP_ASSERT(lbl, prop, msg)
`define CRFP_IMPLIES(lbl, ante, cons, msg)
`define CRFP_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/crfp_pkg.sv]
// Types and character constants for the response field parser.
// No dependencies; used by crfp_number and creg_response_field_parser.
`default_nettype none
package crfp_pkg;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic [7:0]  NUM_SAT        = 8'd255;
   localparam logic [8:0]  STATUS_FAIL    = 9'h1FF;
   localparam logic [8:0]  STATUS_HOME    = 9'd1;
   localparam logic [8:0]  STATUS_ROAMING = 9'd5;

   typedef enum logic [1:0] {
      NUM_SKIP,
      NUM_SIGN,
      NUM_DIGITS,
      NUM_DONE
   } num_phase_type;

   typedef enum logic [3:0] {
      SCAN_COLON,
      SCAN_F1_SKIP,
      SCAN_F1,
      SCAN_F2_OPEN,
      SCAN_F2,
      SCAN_F3_SKIP,
      SCAN_F3,
      SCAN_F4_SKIP,
      SCAN_DONE
   } scan_phase_type;

   typedef struct packed {
      logic feed;
      logic clear;
   } num_ctrl_type;

endpackage
`default_nettype wire

[hdl/crfp_number.sv]
// Decimal number parser for one field, in the manner of strtol, saturating at 255.
// Depends on crfp_pkg.
`default_nettype none
module crfp_number (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire crfp_pkg::num_ctrl_type ctrl,
   input  wire logic [7:0]            line_byte,
   output logic      [7:0]            num_value,
   output logic                       num_negative
);

   crfp_pkg::num_phase_type phase_ff, phase_in;
   logic [7:0]  value_ff, value_in;
   logic        neg_ff, neg_in;
   logic        is_digit, is_white, is_sign;
   logic [11:0] prod;

   assign is_digit = (line_byte >= crfp_pkg::CHAR_ZERO) && (line_byte <= crfp_pkg::CHAR_NINE);
   assign is_white = (line_byte == crfp_pkg::CHAR_SPACE) ||
                     ((line_byte >= crfp_pkg::CHAR_TAB) && (line_byte <= crfp_pkg::CHAR_CR));
   assign is_sign  = (line_byte == crfp_pkg::CHAR_PLUS) || (line_byte == crfp_pkg::CHAR_MINUS);
   assign prod     = {1'b0, value_ff, 3'b000} + {3'b000, value_ff, 1'b0} +
                     {8'd0, line_byte[3:0] - crfp_pkg::CHAR_ZERO[3:0]};

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (ctrl.feed) begin
         unique case (phase_ff)
            crfp_pkg::NUM_SKIP: begin
               if (is_white) begin
                  phase_in = crfp_pkg::NUM_SKIP;
               end else if (is_sign) begin
                  phase_in = crfp_pkg::NUM_SIGN;
               end else begin
                  phase_in = is_digit ? crfp_pkg::NUM_DIGITS : crfp_pkg::NUM_DONE;
               end
            end
            crfp_pkg::NUM_SIGN, crfp_pkg::NUM_DIGITS: begin
               phase_in = is_digit ? crfp_pkg::NUM_DIGITS : crfp_pkg::NUM_DONE;
            end
            crfp_pkg::NUM_DONE: begin
               phase_in = crfp_pkg::NUM_DONE;
            end
            default: begin
               phase_in = crfp_pkg::NUM_DONE;
            end
         endcase
      end
   end

   // Value and sign.
   always_comb begin
      value_in = value_ff;
      neg_in   = neg_ff;
      if (ctrl.feed) begin
         if ((phase_ff == crfp_pkg::NUM_SKIP) && is_sign) begin
            neg_in = (line_byte == crfp_pkg::CHAR_MINUS);
         end else if ((phase_ff != crfp_pkg::NUM_DONE) && is_digit &&
                      !((phase_ff == crfp_pkg::NUM_SKIP) && is_white)) begin
            value_in = (prod > 12'(crfp_pkg::NUM_SAT)) ? crfp_pkg::NUM_SAT : prod[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         phase_ff <= crfp_pkg::NUM_SKIP;
         value_ff <= 8'd0;
         neg_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         value_ff <= value_in;
         neg_ff   <= neg_in;
      end
   end

   // The values after this byte, so that the line's last byte counts.
   assign num_value    = value_in;
   assign num_negative = neg_in;

endmodule
`default_nettype wire

[hdl/creg_response_field_parser.sv]
// Top level of the registration response field parser: scan control, field offsets, result.
// Depends on crfp_pkg, crfp_number and assert_macros.svh.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+------------------------------------------
//   req     | in        | req_valid/req_ready  | line_byte, line_end
//   rsp     | out       | rsp_valid/rsp_ready  | parse_ok, registered, reg_status, area/cell
//
// One byte is taken per cycle while req_ready is high. A byte first lands in an input
// register; from there the scan logic and both number parsers advance on it and, for the
// last byte of a line, the result register is loaded; rsp_valid comes from that register.
// A held byte that closes no line always moves on; a last byte waits in the input register,
// with req_ready low, only while an earlier result is still held and not being taken.
// Reset is synchronous and clears all scan state, which also returns to it after each line.
`default_nettype none
`include "assert_macros.svh"
module creg_response_field_parser #(
   parameter int MAX_LINE = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_line_byte,
   input  wire logic              req_line_end,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_parse_ok,
   output logic                   rsp_registered,
   output logic signed [8:0]      rsp_reg_status,
   output logic                   rsp_area_present,
   output logic [7:0]             rsp_area_start,
   output logic [7:0]             rsp_area_length,
   output logic [7:0]             rsp_cell_start,
   output logic [7:0]             rsp_cell_length
);

   // Position counter holds MAX_LINE itself; stored offsets are always below it.
   localparam int PW = $clog2(MAX_LINE + 1);
   localparam int AW = $clog2(MAX_LINE);
   // Working width for lengths and clipping, at least wide enough to hold 255.
   localparam int XW = (PW > 9) ? PW : 9;

   typedef struct packed {
      logic [3:0] open;
      logic [3:0] close;
   } scan_act_type;

   function automatic logic [7:0] clip8(input logic [XW-1:0] v);
      return (v > XW'(255)) ? 8'hFF : v[7:0];
   endfunction

   // Input register.
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       fire;
   logic       load;

   // Scan state.
   crfp_pkg::scan_phase_type phase_ff, phase_in;
   scan_act_type             act;
   logic [PW-1:0]            pos_ff, pos_in;
   logic [AW-1:0]            start_ff [4];
   logic [AW-1:0]            start_in [4];
   logic [AW-1:0]            end_ff [4];
   logic [AW-1:0]            end_in [4];
   logic [3:0]               found_ff, found_in;
   logic                     in_range;
   logic                     scan_en;
   logic                     is_space, is_comma;

   // Number parsers for fields 1 and 2.
   crfp_pkg::num_ctrl_type   num_ctrl [2];
   logic [7:0]               num_value [2];
   logic                     num_negative [2];

   // Result path.
   logic [XW-1:0]            len [1:3];
   logic [7:0]               st8 [1:3];
   logic                     closed [1:3];
   logic                     ok, sel2, stat_neg;
   logic [8:0]               mag9, status;
   logic                     area;
   logic [7:0]               a_s, a_l, c_s, c_l;

   // Result register.
   logic                     rsp_valid_ff;
   logic                     ok_ff, registered_ff, area_ff;
   logic [8:0]               status_ff;
   logic [7:0]               a_s_ff, a_l_ff, c_s_ff, c_l_ff;

   // A held byte advances unless it closes a line and the result slot stays occupied.
   assign fire      = in_vld_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign load      = fire && in_last_ff;
   assign req_ready = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_line_byte;
         in_last_ff <= req_line_end;
      end
   end

   assign in_range = (pos_ff < PW'(MAX_LINE));
   assign scan_en  = fire && in_range && (phase_ff != crfp_pkg::SCAN_DONE);
   assign is_space = (in_byte_ff == crfp_pkg::CHAR_SPACE);
   assign is_comma = (in_byte_ff == crfp_pkg::CHAR_COMMA);
   assign pos_in   = (fire && in_range) ? pos_ff + PW'(1) : pos_ff;

   // Next scan phase.
   always_comb begin
      phase_in = phase_ff;
      if (scan_en) begin
         unique case (phase_ff)
            crfp_pkg::SCAN_COLON: begin
               if (in_byte_ff == crfp_pkg::CHAR_COLON) phase_in = crfp_pkg::SCAN_F1_SKIP;
            end
            crfp_pkg::SCAN_F1_SKIP: begin
               if (is_comma) phase_in = crfp_pkg::SCAN_F2_OPEN;
               else if (!is_space) phase_in = crfp_pkg::SCAN_F1;
            end
            crfp_pkg::SCAN_F1: begin
               if (is_comma) phase_in = crfp_pkg::SCAN_F2_OPEN;
            end
            crfp_pkg::SCAN_F2_OPEN: begin
               phase_in = is_comma ? crfp_pkg::SCAN_F3_SKIP : crfp_pkg::SCAN_F2;
            end
            crfp_pkg::SCAN_F2: begin
               if (is_comma) phase_in = crfp_pkg::SCAN_F3_SKIP;
            end
            crfp_pkg::SCAN_F3_SKIP: begin
               if (is_comma) phase_in = crfp_pkg::SCAN_F4_SKIP;
               else if (!is_space) phase_in = crfp_pkg::SCAN_F3;
            end
            crfp_pkg::SCAN_F3: begin
               if (is_comma) phase_in = crfp_pkg::SCAN_F4_SKIP;
            end
            crfp_pkg::SCAN_F4_SKIP: begin
               if (!is_space) phase_in = crfp_pkg::SCAN_DONE;
            end
            crfp_pkg::SCAN_DONE: begin
               phase_in = crfp_pkg::SCAN_DONE;
            end
            default: begin
               phase_in = crfp_pkg::SCAN_DONE;
            end
         endcase
      end
   end

   // Field open and close actions of the scan.
   always_comb begin
      act = '0;
      if (scan_en) begin
         unique case (phase_ff)
            crfp_pkg::SCAN_F1_SKIP: begin
               act.open[0]  = !is_space;
               act.close[0] = is_comma;
            end
            crfp_pkg::SCAN_F1: begin
               act.close[0] = is_comma;
            end
            crfp_pkg::SCAN_F2_OPEN: begin
               act.open[1]  = 1'b1;
               act.close[1] = is_comma;
            end
            crfp_pkg::SCAN_F2: begin
               act.close[1] = is_comma;
            end
            crfp_pkg::SCAN_F3_SKIP: begin
               act.open[2]  = !is_space;
               act.close[2] = is_comma;
            end
            crfp_pkg::SCAN_F3: begin
               act.close[2] = is_comma;
            end
            crfp_pkg::SCAN_F4_SKIP: begin
               act.open[3]  = !is_space;
            end
            default: begin
               act = '0;
            end
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         start_in[k] = act.open[k]  ? pos_ff[AW-1:0] : start_ff[k];
         end_in[k]   = act.close[k] ? pos_ff[AW-1:0] : end_ff[k];
      end
      found_in = found_ff | act.open;
   end

   always_ff @(posedge clock) begin
      if (reset || load) begin
         phase_ff <= crfp_pkg::SCAN_COLON;
         pos_ff   <= '0;
         found_ff <= '0;
         for (int k = 0; k < 4; k++) begin
            start_ff[k] <= '0;
            end_ff[k]   <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         found_ff <= found_in;
         for (int k = 0; k < 4; k++) begin
            start_ff[k] <= start_in[k];
            end_ff[k]   <= end_in[k];
         end
      end
   end

   // A number parser listens from the byte that opens its field onwards.
   for (genvar g = 0; g < 2; g++) begin : g_num
      assign num_ctrl[g].feed  = scan_en && found_in[g];
      assign num_ctrl[g].clear = load;

      crfp_number u_number (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (num_ctrl[g]),
         .line_byte    (in_byte_ff),
         .num_value    (num_value[g]),
         .num_negative (num_negative[g])
      );
   end

   // Result from the state as it stands after the last byte. A field that was
   // closed ends at its comma, otherwise at the line end.
   assign closed[1] = (phase_in >= crfp_pkg::SCAN_F3_SKIP);
   assign closed[2] = (phase_in >= crfp_pkg::SCAN_F4_SKIP);
   assign closed[3] = 1'b0;

   always_comb begin
      for (int k = 1; k <= 3; k++) begin
         logic [XW-1:0] st, en;
         st     = XW'(start_in[k]);
         en     = closed[k] ? XW'(end_in[k]) : XW'(pos_in);
         len[k] = (en >= st) ? en - st : '0;
         st8[k] = clip8(st);
      end
   end

   assign ok       = (phase_in >= crfp_pkg::SCAN_F1);
   // Status comes from field 2 when exactly two or four fields started.
   assign sel2     = (found_in[1] && !found_in[2] && !found_in[3]) ||
                     (found_in[1] && found_in[2] && found_in[3]);
   assign mag9     = {1'b0, sel2 ? num_value[1] : num_value[0]};
   assign stat_neg = sel2 ? num_negative[1] : num_negative[0];
   assign status   = !ok ? crfp_pkg::STATUS_FAIL : (stat_neg ? 9'(-mag9) : mag9);

   always_comb begin
      area = 1'b0;
      a_s  = 8'd0;
      a_l  = 8'd0;
      c_s  = 8'd0;
      c_l  = 8'd0;
      priority if (ok && found_in[1] && found_in[2] && !found_in[3]) begin
         area = 1'b1;
         a_s  = st8[1];
         a_l  = clip8(len[1]);
         c_s  = st8[2];
         c_l  = clip8(len[2]);
      end else if (ok && found_in[2] && found_in[3]) begin
         area = 1'b1;
         a_s  = st8[2];
         a_l  = clip8(len[2]);
         c_s  = st8[3];
         c_l  = clip8(len[3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ok_ff         <= ok;
         registered_ff <= (status == crfp_pkg::STATUS_HOME) ||
                          (status == crfp_pkg::STATUS_ROAMING);
         status_ff     <= status;
         area_ff       <= area;
         a_s_ff        <= a_s;
         a_l_ff        <= a_l;
         c_s_ff        <= c_s;
         c_l_ff        <= c_l;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parse_ok     = ok_ff;
   assign rsp_registered   = registered_ff;
   assign rsp_reg_status   = status_ff;
   assign rsp_area_present = area_ff;
   assign rsp_area_start   = a_s_ff;
   assign rsp_area_length  = a_l_ff;
   assign rsp_cell_start   = c_s_ff;
   assign rsp_cell_length  = c_l_ff;

   // A failed parse reports status -1 and no area fields.
   `CRFP_IMPLIES(a_fail_status, rsp_valid_ff && !ok_ff,
                 (status_ff == crfp_pkg::STATUS_FAIL) && !area_ff,
                 "failed parse without status -1")
   // The registered flag agrees with the status it was derived from.
   `CRFP_IMPLIES(a_registered, rsp_valid_ff && registered_ff,
                 (status_ff == crfp_pkg::STATUS_HOME) || (status_ff == crfp_pkg::STATUS_ROAMING),
                 "registered flag without home or roaming status")
   // Closing a line returns the scan to its start and presents a result.
   `CRFP_NEXT(a_line_close, load,
              (phase_ff == crfp_pkg::SCAN_COLON) && (pos_ff == '0) && rsp_valid_ff,
              "scan state not reset after line end")
   // The position counter never runs past the line limit.
   `CRFP_ASSERT(a_pos_bound, pos_ff <= PW'(MAX_LINE), "byte position beyond line limit")

endmodule
`default_nettype wire
